// ===== rtl/tlr_pkg.sv =====
// ----------------------------------------------------------------------------
// tlr_pkg: thick line rasterizer shared types and constants
// Sequencer states, register indexes, result record and clipping helpers.
// ----------------------------------------------------------------------------
package tlr_pkg;

    localparam int COORD_W    = 14;
    localparam int DELTA_W    = 15;
    localparam int ERR_W      = 17;
    localparam int E2_W       = 23;
    localparam int REACH_W    = 52;
    localparam int WQ_W       = 10;
    localparam int DIM_W      = 13;
    localparam int PIX_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int CNT_W      = 7;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 56;

    localparam logic [WQ_W-1:0]  WIDTH_MAX_Q4 = 10'd640;
    localparam logic [WQ_W-1:0]  HALF_PIXEL   = 10'd16;
    localparam logic [CNT_W-1:0] RESULT_CAP   = 7'd64;
    localparam logic [DIM_W-1:0] DIM_MAX      = 13'd4096;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DRAW_COLOR   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RR,
        S_LD_CC,
        S_LD_WW,
        S_LD_REACH,
        S_F1_SQ,
        S_F1_TST,
        S_F2_SQ,
        S_F2_TST,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [PIX_W-1:0]   row;
        logic [PIX_W-1:0]   col;
        logic [COLOR_W-1:0] value;
        logic               plotted;
        logic               line_done;
    } pix_t;

    function automatic logic in_image(
        input logic signed [COORD_W:0] row,
        input logic signed [COORD_W:0] col,
        input logic [DIM_W-1:0]        height,
        input logic [DIM_W-1:0]        width
    );
        logic [DIM_W-1:0] h_eff;
        logic [DIM_W-1:0] w_eff;
        h_eff = (height > DIM_MAX) ? DIM_MAX : height;
        w_eff = (width > DIM_MAX) ? DIM_MAX : width;
        return !row[COORD_W] && !col[COORD_W]
            && (row[COORD_W-1:0] < {1'b0, h_eff})
            && (col[COORD_W-1:0] < {1'b0, w_eff});
    endfunction

    function automatic pix_t make_pixel(
        input logic signed [COORD_W:0] row,
        input logic signed [COORD_W:0] col,
        input logic [COLOR_W-1:0]      color,
        input logic                    done
    );
        pix_t p;
        p.row       = row[PIX_W-1:0];
        p.col       = col[PIX_W-1:0];
        p.value     = color;
        p.plotted   = 1'b1;
        p.line_done = done;
        return p;
    endfunction

    function automatic pix_t make_blank(input logic done);
        pix_t p;
        p           = '0;
        p.line_done = done;
        return p;
    endfunction

endpackage

// ===== rtl/thick_line_rasterizer_core.sv =====
// A load is the transfer plus four passes of the shared multiplier (S_LD_RR, S_LD_CC,
// S_LD_WW, S_LD_REACH). An advance runs one or both fill loops, with up to 63 fill
// passes per step: each pass squares the error on the shared multiplier in its SQ
// state, then tests it and issues a result in its TST state; an idle advance flushes.
// Throughput: one item at a time; s_tready is high only between items.
// Reset (rst_n low, asynchronous) clears the line, the sequencer and the output.
// ----------------------------------------------------------------------------
// thick_line_rasterizer_core: thick line rasterizer
// Error-distance Bresenham walk with perpendicular fill, one shared multiplier.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_row, start_col, end_row, end_col, width_q4, zero pad
    input  logic [tlr_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_row, pixel_col, pixel_value
    output logic [tlr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // plotted, line_done
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [tlr_pkg::COLOR_W-1:0]      cfg_data
);
    import tlr_pkg::*;

    state_t                    state_reg, state_next;
    logic signed [COORD_W-1:0] cur_row_reg, cur_row_next;
    logic signed [COORD_W-1:0] cur_col_reg, cur_col_next;
    logic signed [COORD_W-1:0] last_row_reg, last_row_next;
    logic signed [COORD_W-1:0] last_col_reg, last_col_next;
    logic [DELTA_W-1:0]        dr_reg, dr_next;
    logic [DELTA_W-1:0]        dc_reg, dc_next;
    logic [1:0]                signs_reg, signs_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [REACH_W-1:0]        reach_reg, reach_next;
    logic                      active_reg, active_next;
    logic [WQ_W-1:0]           wq_reg, wq_next;
    logic [31:0]               acc_reg, acc_next;
    logic [REACH_W-1:0]        prod_reg, prod_next;
    logic signed [E2_W-1:0]    e2_reg, e2_next;
    logic signed [COORD_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      br2_reg, br2_next;
    logic                      done_reg, done_next;
    logic                      pend_valid_reg, pend_valid_next;
    pix_t                      pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;
    pix_t                      out_reg, out_next;
    logic                      out_last_reg, out_last_next;
    logic [DIM_W-1:0]          width_reg, width_next;
    logic [DIM_W-1:0]          height_reg, height_next;
    logic [COLOR_W-1:0]        color_reg, color_next;

    logic                      out_free;
    logic                      in_xfer;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_p;
    logic signed [COORD_W:0]   in_sr, in_sc, in_er, in_ec;
    logic signed [COORD_W:0]   diff_r, diff_c;
    logic [DELTA_W-1:0]        abs_r, abs_c;
    logic [WQ_W-1:0]           w_in, w_sat;
    logic signed [ERR_W:0]     two_err;
    logic                      c1, c2, done1, done_any;
    logic signed [COORD_W:0]   row_step, col_step;
    logic signed [COORD_W:0]   cur_row_x, cur_col_x, pos_x;
    logic signed [COORD_W:0]   test_col, test_row;
    logic [E2_W-2:0]           e2_abs;
    logic                      reach_ok;
    logic                      cond1, cond2;
    logic signed [E2_W-1:0]    err_x, dr_x, dc_x;
    logic [31:0]               dsum;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.value, out_reg.col, out_reg.row};
    assign m_tuser  = {out_reg.line_done, out_reg.plotted};
    assign m_tlast  = out_last_reg;

    assign in_sr  = {s_tdata[13], s_tdata[13:0]};
    assign in_sc  = {s_tdata[27], s_tdata[27:14]};
    assign in_er  = {s_tdata[41], s_tdata[41:28]};
    assign in_ec  = {s_tdata[55], s_tdata[55:42]};
    assign w_in   = s_tdata[65:56];
    assign diff_r = in_er - in_sr;
    assign diff_c = in_ec - in_sc;
    assign abs_r  = diff_r[COORD_W] ? DELTA_W'(-diff_r) : DELTA_W'(diff_r);
    assign abs_c  = diff_c[COORD_W] ? DELTA_W'(-diff_c) : DELTA_W'(diff_c);
    assign w_sat  = (w_in > WIDTH_MAX_Q4) ? WIDTH_MAX_Q4 : w_in;

    assign err_x    = E2_W'(err_reg);
    assign dr_x     = $signed({{(E2_W-DELTA_W){1'b0}}, dr_reg});
    assign dc_x     = $signed({{(E2_W-DELTA_W){1'b0}}, dc_reg});
    assign two_err  = {err_reg, 1'b0};
    assign c1       = two_err >= -$signed({{(ERR_W-DELTA_W+1){1'b0}}, dr_reg});
    assign c2       = two_err <= $signed({{(ERR_W-DELTA_W+1){1'b0}}, dc_reg});
    assign done1    = c1 && (cur_row_reg == last_row_reg);
    assign done_any = done1 || (c2 && (cur_col_reg == last_col_reg));

    assign row_step  = signs_reg[0] ? -(COORD_W+1)'(1) : (COORD_W+1)'(1);
    assign col_step  = signs_reg[1] ? -(COORD_W+1)'(1) : (COORD_W+1)'(1);
    assign cur_row_x = {cur_row_reg[COORD_W-1], cur_row_reg};
    assign cur_col_x = {cur_col_reg[COORD_W-1], cur_col_reg};
    assign pos_x     = {pos_reg[COORD_W-1], pos_reg};
    assign test_col  = pos_x + col_step;
    assign test_row  = pos_x + row_step;

    assign e2_abs   = e2_reg[E2_W-1] ? (E2_W-1)'(-e2_reg) : e2_reg[E2_W-2:0];
    assign reach_ok = e2_reg[E2_W-1]
        || ({prod_reg[43:0], 10'b0} < {2'b0, reach_reg});
    assign cond1 = (cnt_reg < RESULT_CAP) && reach_ok
        && ((last_col_reg != pos_reg) || (dr_reg > dc_reg));
    assign cond2 = (cnt_reg < RESULT_CAP) && reach_ok
        && ((last_row_reg != pos_reg) || (dr_reg < dc_reg));

    assign mul_p = mul_a * mul_b;
    assign dsum  = acc_reg + prod_reg[31:0];

    always_comb
    begin
        unique case (state_reg) inside
            S_LD_RR:
            begin
                mul_a = {17'b0, dr_reg};
                mul_b = {17'b0, dr_reg};
            end
            S_LD_CC:
            begin
                mul_a = {17'b0, dc_reg};
                mul_b = {17'b0, dc_reg};
            end
            S_LD_WW:
            begin
                mul_a = {22'b0, wq_reg};
                mul_b = {22'b0, wq_reg};
            end
            S_LD_REACH:
            begin
                mul_a = acc_reg;
                mul_b = {12'b0, prod_reg[19:0]};
            end
            S_F1_SQ, S_F2_SQ:
            begin
                mul_a = {10'b0, e2_abs};
                mul_b = {10'b0, e2_abs};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        last_row_next   = last_row_reg;
        last_col_next   = last_col_reg;
        dr_next         = dr_reg;
        dc_next         = dc_reg;
        signs_next      = signs_reg;
        err_next        = err_reg;
        reach_next      = reach_reg;
        active_next     = active_reg;
        wq_next         = wq_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        e2_next         = e2_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        br2_next        = br2_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        color_next      = color_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_next = cfg_data[DIM_W-1:0];
                CFG_DRAW_COLOR:   color_next  = cfg_data;
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (s_tuser == KIND_LOAD))
                begin
                    cur_row_next  = in_sr[COORD_W-1:0];
                    cur_col_next  = in_sc[COORD_W-1:0];
                    last_row_next = in_er[COORD_W-1:0];
                    last_col_next = in_ec[COORD_W-1:0];
                    dr_next       = abs_r;
                    dc_next       = abs_c;
                    signs_next    = {!(in_sc < in_ec), !(in_sr < in_er)};
                    err_next      = $signed({2'b0, abs_r}) - $signed({2'b0, abs_c});
                    wq_next       = w_sat + HALF_PIXEL;
                    active_next   = 1'b1;
                    state_next    = S_LD_RR;
                end
                else if (in_xfer && !active_reg)
                begin
                    pend_next       = make_blank(1'b1);
                    pend_valid_next = 1'b1;
                    done_next       = 1'b1;
                    state_next      = S_FLUSH;
                end
                else if (in_xfer)
                begin
                    done_next       = done_any;
                    br2_next        = c2;
                    cnt_next        = CNT_W'(1);
                    pend_valid_next = 1'b1;
                    if (in_image(cur_row_x, cur_col_x, height_reg, width_reg))
                    begin
                        pend_next = make_pixel(cur_row_x, cur_col_x, color_reg, done_any);
                    end
                    else
                    begin
                        pend_next = make_blank(done_any);
                    end
                    if (c1)
                    begin
                        e2_next    = err_x + dc_x;
                        pos_next   = cur_col_reg;
                        state_next = S_F1_SQ;
                    end
                    else if (c2)
                    begin
                        e2_next    = dr_x - err_x;
                        pos_next   = cur_row_reg;
                        state_next = S_F2_SQ;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_LD_RR:
            begin
                prod_next  = mul_p[REACH_W-1:0];
                state_next = S_LD_CC;
            end
            S_LD_CC:
            begin
                acc_next   = prod_reg[31:0];
                prod_next  = mul_p[REACH_W-1:0];
                state_next = S_LD_WW;
            end
            S_LD_WW:
            begin
                acc_next   = (dsum == 32'd0) ? 32'd1 : dsum;
                prod_next  = mul_p[REACH_W-1:0];
                state_next = S_LD_REACH;
            end
            S_LD_REACH:
            begin
                reach_next = mul_p[REACH_W-1:0];
                state_next = S_IDLE;
            end
            S_F1_SQ:
            begin
                prod_next  = mul_p[REACH_W-1:0];
                state_next = S_F1_TST;
            end
            S_F1_TST:
            begin
                if (cond1)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        if (in_image(cur_row_x, test_col, height_reg, width_reg))
                        begin
                            pos_next  = test_col[COORD_W-1:0];
                            pend_next = make_pixel(cur_row_x, test_col, color_reg, done_reg);
                        end
                        else
                        begin
                            pend_next = make_blank(done_reg);
                        end
                        e2_next    = e2_reg + dr_x;
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_F1_SQ;
                    end
                end
                else if (cur_row_reg == last_row_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    err_next     = err_reg - $signed({2'b0, dc_reg});
                    cur_row_next = cur_row_reg + row_step[COORD_W-1:0];
                    if (br2_reg)
                    begin
                        e2_next    = dr_x - err_x;
                        pos_next   = cur_row_reg;
                        state_next = S_F2_SQ;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_F2_SQ:
            begin
                prod_next  = mul_p[REACH_W-1:0];
                state_next = S_F2_TST;
            end
            S_F2_TST:
            begin
                if (cond2)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        if (in_image(test_row, cur_col_x, height_reg, width_reg))
                        begin
                            pos_next  = test_row[COORD_W-1:0];
                            pend_next = make_pixel(test_row, cur_col_x, color_reg, done_reg);
                        end
                        else
                        begin
                            pend_next = make_blank(done_reg);
                        end
                        e2_next    = e2_reg + dc_x;
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_F2_SQ;
                    end
                end
                else
                begin
                    if (cur_col_reg != last_col_reg)
                    begin
                        err_next     = err_reg + $signed({2'b0, dr_reg});
                        cur_col_next = cur_col_reg + col_step[COORD_W-1:0];
                    end
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    if (done_reg)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            last_row_reg   <= '0;
            last_col_reg   <= '0;
            dr_reg         <= '0;
            dc_reg         <= '0;
            signs_reg      <= '0;
            err_reg        <= '0;
            reach_reg      <= '0;
            active_reg     <= 1'b0;
            wq_reg         <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            e2_reg         <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            br2_reg        <= 1'b0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            out_last_reg   <= 1'b0;
            width_reg      <= 13'd640;
            height_reg     <= 13'd480;
            color_reg      <= 32'h00FF_0000;
        end
        else
        begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            last_row_reg   <= last_row_next;
            last_col_reg   <= last_col_next;
            dr_reg         <= dr_next;
            dc_reg         <= dc_next;
            signs_reg      <= signs_next;
            err_reg        <= err_next;
            reach_reg      <= reach_next;
            active_reg     <= active_next;
            wq_reg         <= wq_next;
            acc_reg        <= acc_next;
            prod_reg       <= prod_next;
            e2_reg         <= e2_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            br2_reg        <= br2_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            out_last_reg   <= out_last_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            color_reg      <= color_next;
        end
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over between items");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RESULT_CAP)
        else $error("result count exceeds the cap");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && out_free) |=> (m_tvalid && m_tlast && state_reg == S_IDLE))
        else $error("flush did not issue the closing transfer");

    a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tuser == KIND_LOAD) |=> (state_reg == S_LD_RR && active_reg))
        else $error("load did not start the reach sequence");

    a_fill_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F1_TST || state_reg == S_F2_TST || state_reg == S_FLUSH)
        |-> pend_valid_reg)
        else $error("fill step without a held result");

endmodule
